// ===== design/htb_pkg.sv =====
// Package for the Huffman tree builder: item structs, queue entry type,
// command, status and state codes. No dependencies.
package htb_pkg;

  // Fixed field widths of the channel items
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned SYMBOL_W     = 8;
  localparam int unsigned LEAF_COUNT_W = 24;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned NODE_ID_W    = 9;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned INT_ID_W     = 8;

  // Command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_MERGE = 2'd2
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE     = 3'd0,
    STAT_MERGED   = 3'd1,
    STAT_COMPLETE = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_FULL     = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CPL,
    S_MRG_RD1,
    S_MRG_SUM,
    S_INS_START,
    S_INS_SCAN,
    S_INS_HEAD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SYMBOL_W-1:0]     leaf_symbol;
    logic [LEAF_COUNT_W-1:0] leaf_count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [NODE_ID_W-1:0] node_id;
    logic [NODE_ID_W-1:0] left_id;
    logic [NODE_ID_W-1:0] right_id;
    logic [WEIGHT_W-1:0]  node_weight;
    logic                 finished;
  } out_item_t;

  // One queue entry: a tree root
  typedef struct packed {
    logic [WEIGHT_W-1:0]  weight;
    logic [NODE_ID_W-1:0] id;
  } entry_t;

endpackage

// ===== design/htb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module htb_ram #(
  parameter int unsigned WIDTH = 41,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/huffman_tree_builder.sv =====
// Huffman tree builder: sorted queue of tree roots held in one RAM.
// Depends on htb_pkg and htb_ram.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries commands:
//   clear, add leaf (symbol, count) or one merge step. Output channel
//   (out_valid_o / out_stall_i / out_data_o) returns exactly one result per
//   command. A transfer happens on a rising edge with valid high, stall low.
//   The queue is a circular buffer in RAM: pops move the head pointer, and a
//   sorted insert walks from the tail toward the head, moving each heavier
//   entry up one slot, one entry per cycle through the single write port.
//   Every command passes through dispatch to the response state: clear, add
//   to a full queue, empty merge and unused modes go straight there; a merge
//   with one entry reads the head and reports complete; an add runs the
//   sorted insert; a merge reads the two head entries, sums them and then
//   runs the sorted insert of the new node.
//   One command is in work at a time; a new one is taken once the previous
//   result sits in the output register. The number of entries an insert
//   moves is bounded by MAX_SYMBOLS.
//   Reset empties the queue and restarts internal ids at 256; RAM contents
//   are not cleared since only live entries are ever read. A stalled output
//   holds its result; the block finishes the next command into a holding
//   register and waits there until the output register frees.
module huffman_tree_builder
  import htb_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 256,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned PTR_W  = $clog2(MAX_SYMBOLS);
  localparam int unsigned CNT_W  = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned KeepBits =
      (COUNT_BITS < LEAF_COUNT_W) ? COUNT_BITS : LEAF_COUNT_W;
  localparam logic [LEAF_COUNT_W-1:0] CountMask =
      LEAF_COUNT_W'((64'd1 << KeepBits) - 64'd1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_SYMBOLS);

  // map a queue position to a RAM address relative to the head
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                            input logic [PTR_W-1:0] pos);
    logic [PTR_W:0] s;
    s = {1'b0, head} + {1'b0, pos};
    if (s >= (PTR_W+1)'(MAX_SYMBOLS)) begin
      s = s - (PTR_W+1)'(MAX_SYMBOLS);
    end
    return s[PTR_W-1:0];
  endfunction

  state_e                state_q, state_d;
  in_item_t              cmd_q, cmd_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [INT_ID_W-1:0]   nid_q, nid_d;
  logic [PTR_W-1:0]      idx_q, idx_d;
  entry_t                ins_q, ins_d;
  entry_t                left_q, left_d;
  out_item_t             res_q, res_d;
  out_item_t             out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  wr_en, rd_en;
  logic [PTR_W-1:0]      wr_addr, rd_addr;
  entry_t                wr_data, rd_data;

  logic                  out_free;
  logic                  full;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      tail_w;
  logic [WEIGHT_W:0]     sum_w;
  logic [WEIGHT_W-1:0]   sum_sat;
  logic [NODE_ID_W-1:0]  new_id;

  htb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_SYMBOLS)
  ) u_queue_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // shared helpers
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q >= CntMax);
  assign tail_w   = cnt_q - CNT_W'(1);
  assign tail     = tail_w[PTR_W-1:0];
  assign sum_w    = {1'b0, left_q.weight} + {1'b0, rd_data.weight};
  assign sum_sat  = sum_w[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum_w[WEIGHT_W-1:0];
  assign new_id   = {1'b1, nid_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (cmd_q.mode)
          MODE_ADD:   state_d = full ? S_RESP : S_INS_START;
          MODE_MERGE: begin
            if (cnt_q == CNT_W'(0))      state_d = S_RESP;
            else if (cnt_q == CNT_W'(1)) state_d = S_CPL;
            else                         state_d = S_MRG_RD1;
          end
          default:    state_d = S_RESP;
        endcase
      end
      S_CPL:       state_d = S_RESP;
      S_MRG_RD1:   state_d = S_MRG_SUM;
      S_MRG_SUM:   state_d = S_INS_START;
      S_INS_START: state_d = (cnt_q == CNT_W'(0)) ? S_INS_HEAD : S_INS_SCAN;
      S_INS_SCAN: begin
        if (rd_data.weight >= ins_q.weight) begin
          if (idx_q == PTR_W'(0)) state_d = S_INS_HEAD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_INS_HEAD:  state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath, RAM control and output register
  always_comb begin
    cmd_d       = cmd_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    nid_d       = nid_q;
    idx_d       = idx_q;
    ins_d       = ins_q;
    left_d      = left_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = ins_q;
    rd_en       = 1'b0;
    rd_addr     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) cmd_d = in_data_i;
      end
      S_DISPATCH: begin
        // head read is issued for every command; complete and merge use it
        rd_en   = 1'b1;
        rd_addr = head_q;
        res_d   = '0;
        case (cmd_q.mode)
          MODE_CLEAR: begin
            cnt_d  = '0;
            head_d = '0;
            nid_d  = '0;
          end
          MODE_ADD: begin
            if (full) begin
              res_d.status = STAT_FULL;
            end else begin
              ins_d.weight = WEIGHT_W'(cmd_q.leaf_count & CountMask);
              ins_d.id     = {1'b0, cmd_q.leaf_symbol};
            end
          end
          MODE_MERGE: begin
            if (cnt_q == CNT_W'(0)) res_d.status = STAT_EMPTY;
          end
          default: ;
        endcase
      end
      S_CPL: begin
        res_d.status      = STAT_COMPLETE;
        res_d.node_id     = rd_data.id;
        res_d.node_weight = rd_data.weight;
      end
      S_MRG_RD1: begin
        left_d  = rd_data;
        rd_en   = 1'b1;
        rd_addr = phys(head_q, PTR_W'(1));
      end
      S_MRG_SUM: begin
        res_d.status      = STAT_MERGED;
        res_d.node_id     = new_id;
        res_d.left_id     = left_q.id;
        res_d.right_id    = rd_data.id;
        res_d.node_weight = sum_sat;
        ins_d.weight      = sum_sat;
        ins_d.id          = new_id;
        nid_d             = nid_q + INT_ID_W'(1);
        head_d            = phys(head_q, PTR_W'(2));
        cnt_d             = cnt_q - CNT_W'(2);
      end
      S_INS_START: begin
        if (cnt_q != CNT_W'(0)) begin
          rd_en   = 1'b1;
          rd_addr = phys(head_q, tail);
          idx_d   = tail;
        end
      end
      S_INS_SCAN: begin
        wr_en   = 1'b1;
        wr_addr = phys(head_q, idx_q + PTR_W'(1));
        if (rd_data.weight >= ins_q.weight) begin
          // heavier or equal entry moves up one slot
          wr_data = rd_data;
          if (idx_q != PTR_W'(0)) begin
            rd_en   = 1'b1;
            rd_addr = phys(head_q, idx_q - PTR_W'(1));
            idx_d   = idx_q - PTR_W'(1);
          end
        end else begin
          wr_data = ins_q;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      S_INS_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = head_q;
        wr_data = ins_q;
        cnt_d   = cnt_q + CNT_W'(1);
      end
      S_RESP: begin
        if (out_free) begin
          out_d          = res_q;
          out_d.finished = (cnt_q == CNT_W'(1));
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      nid_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      nid_q       <= nid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    ins_q  <= ins_d;
    left_q <= left_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESP) |-> !wr_en)
    else $error("queue RAM written outside an insert");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result presented without a finished command");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_HEAD) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("head insert did not grow the queue");

  a_merge_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MRG_SUM) |=> cnt_q == $past(cnt_q) - CNT_W'(2))
    else $error("merge did not pop two entries");

endmodule
